// ===== hdl/keyframe_position_sampler_assert.svh =====
// Assertion macros for the keyframe position sampler
`ifndef KEYFRAME_POSITION_SAMPLER_ASSERT_SVH
`define KEYFRAME_POSITION_SAMPLER_ASSERT_SVH
// implication checked every cycle outside reset
`define KPS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define KPS_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hdl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants of the keyframe position sampler.
// ----------------------------------------------------------------------------
package kps_pkg;
  localparam int MaxKeysDefault = 64;
  localparam int CountW = 7;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StSingle = 2'd1;
  localparam logic [1:0] StZeroSpan = 2'd2;

  typedef struct packed {
    logic [31:0] t;
    logic [CountW-1:0] count;
  } kps_cmd_t;
endpackage

// ===== hdl/kps_ram.sv =====
// ----------------------------------------------------------------------------
// kps_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kps_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/kps_front.sv =====
// ----------------------------------------------------------------------------
// kps_front
// Accepts items: performs key writes, queues sample commands (two entries).
// ----------------------------------------------------------------------------
module kps_front #(
  parameter int MaxKeys = kps_pkg::MaxKeysDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [5:0]               in_key_index,
  input  logic [kps_pkg::CountW-1:0] count,
  input  logic [31:0]              in_sample_time,
  input  logic                     back_busy,
  output logic                     key_we,
  output logic [$clog2(MaxKeys)-1:0] key_waddr,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output kps_pkg::kps_cmd_t        cmd
);
  localparam int AW = $clog2(MaxKeys);
  kps_pkg::kps_cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic acc, push, pop;
  logic [31:0] idx_ext;

  assign idx_ext = 32'(in_key_index);
  // key writes must not disturb a sample in flight
  assign in_ready = (in_func) ? (cnt_r != 2'd2) : (cnt_r == 2'd0 && !back_busy);
  assign acc = in_valid && in_ready;
  assign push = acc && in_func;
  assign key_we = acc && !in_func && (idx_ext < 32'(MaxKeys));
  assign key_waddr = AW'(in_key_index);
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd = q_r[rd_r];
  assign pop = cmd_valid && cmd_ready;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt = rd_r ^ pop;
    wr_nxt = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= '{t: in_sample_time, count: count};
    end
  end
endmodule

// ===== hdl/kps_back.sv =====
// ----------------------------------------------------------------------------
// kps_back
// Searches the segment, divides serially, interpolates the three axes.
// ----------------------------------------------------------------------------
module kps_back #(
  parameter int MaxKeys = kps_pkg::MaxKeysDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  kps_pkg::kps_cmd_t        cmd,
  output logic                     busy,
  output logic [$clog2(MaxKeys)-1:0] raddr,
  input  logic [31:0]              rd_t,
  input  logic [31:0]              rd_x,
  input  logic [31:0]              rd_y,
  input  logic [31:0]              rd_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [31:0]              out_pos_x,
  output logic [31:0]              out_pos_y,
  output logic [31:0]              out_pos_z,
  output logic [1:0]               out_status
);
  localparam int AW = $clog2(MaxKeys);
  localparam int CW = $clog2(MaxKeys + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001, S_SRCH = 12'b000000000010, S_SWAIT = 12'b000000000100,
    S_R0 = 12'b000000001000, S_R0W = 12'b000000010000, S_R1 = 12'b000000100000,
    S_R1W = 12'b000001000000, S_DIV = 12'b000010000000, S_MUL = 12'b000100000000,
    S_MULH = 12'b001000000000, S_ADD = 12'b010000000000, S_OUT = 12'b100000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [31:0] t_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] idx_r, seg_r;
  logic [31:0] t0_r, x0_r, y0_r, z0_r;
  logic [32:0] dvs_r, rem_r;
  logic [48:0] quo_r;
  logic [5:0] bit_r;
  logic        fneg_r;
  logic [1:0]  ax_r;
  logic signed [49:0] fval_r;
  logic signed [32:0] diff_r [3];
  logic signed [31:0] p0_r [3];
  logic signed [82:0] prod_r;
  logic [31:0] res_r [3];
  logic [1:0] stat_r;
  logic [CW-1:0] cnt_eff;
  logic [6:0] c7;
  logic [33:0] rtry;
  logic [33:0] rshift;
  logic signed [25:0] mop_w;
  logic signed [58:0] mul_w;
  logic signed [82:0] sum_w;
  logic signed [31:0] sat_w;

  assign c7 = cmd.count;
  always_comb begin
    if (c7 == 7'd0) cnt_eff = CW'(1);
    else if ({25'd0, c7} > 32'(MaxKeys)) cnt_eff = CW'(MaxKeys);
    else cnt_eff = CW'(c7);
  end

  assign cmd_ready = st_r == S_IDLE;
  assign busy = st_r != S_IDLE;
  assign out_valid = st_r == S_OUT;
  assign out_pos_x = res_r[0];
  assign out_pos_y = res_r[1];
  assign out_pos_z = res_r[2];
  assign out_status = stat_r;

  always_comb begin
    case (st_r)
      S_SRCH, S_SWAIT: raddr = idx_r + AW'(1);
      S_R0, S_R0W: raddr = seg_r;
      S_R1, S_R1W: raddr = seg_r + AW'(1);
      default: raddr = '0;
    endcase
  end

  // trial subtract of the restoring divider
  assign rshift = {rem_r, quo_r[48]};
  assign rtry = rshift - {1'b0, dvs_r};

  // multiply the difference by the low, then the high part of the fraction
  assign mop_w = (st_r == S_MULH) ? {fval_r[49], fval_r[49:25]} : {1'b0, fval_r[24:0]};
  assign mul_w = diff_r[ax_r] * mop_w;

  assign sum_w = 83'(p0_r[ax_r]) + (prod_r >>> 16);
  always_comb begin
    if (sum_w > 83'sd2147483647) sat_w = 32'sh7fffffff;
    else if (sum_w < -83'sd2147483648) sat_w = 32'sh80000000;
    else sat_w = sum_w[31:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd_valid) st_nxt = (cnt_eff == CW'(1)) ? S_R0 : S_SRCH;
      S_SRCH: st_nxt = S_SWAIT;
      S_SWAIT: begin
        if (t_r < rd_t || CW'(idx_r) + CW'(2) >= cnt_r) st_nxt = S_R0;
        else st_nxt = S_SRCH;
      end
      S_R0: st_nxt = S_R0W;
      S_R0W: st_nxt = (cnt_r == CW'(1)) ? S_OUT : S_R1;
      S_R1: st_nxt = S_R1W;
      S_R1W: st_nxt = (rd_t <= t0_r) ? S_OUT : S_DIV;
      S_DIV: if (bit_r == 6'd0) st_nxt = S_MUL;
      S_MUL: st_nxt = S_MULH;
      S_MULH: st_nxt = S_ADD;
      S_ADD: st_nxt = (ax_r == 2'd2) ? S_OUT : S_MUL;
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    case (st_r)
      S_IDLE: begin
        t_r <= cmd.t;
        cnt_r <= cnt_eff;
        idx_r <= '0;
        seg_r <= '0;
      end
      S_SWAIT: begin
        if (t_r < rd_t || CW'(idx_r) + CW'(2) >= cnt_r) seg_r <= idx_r;
        else idx_r <= idx_r + AW'(1);
      end
      S_R0W: begin
        t0_r <= rd_t; x0_r <= rd_x; y0_r <= rd_y; z0_r <= rd_z;
        res_r[0] <= rd_x; res_r[1] <= rd_y; res_r[2] <= rd_z;
        stat_r <= kps_pkg::StSingle;
      end
      S_R1W: begin
        stat_r <= kps_pkg::StZeroSpan;
        diff_r[0] <= 33'($signed(rd_x)) - 33'($signed(x0_r));
        diff_r[1] <= 33'($signed(rd_y)) - 33'($signed(y0_r));
        diff_r[2] <= 33'($signed(rd_z)) - 33'($signed(z0_r));
        p0_r[0] <= x0_r; p0_r[1] <= y0_r; p0_r[2] <= z0_r;
        dvs_r <= {1'b0, rd_t - t0_r};
        fneg_r <= t_r < t0_r;
        quo_r <= {(t_r < t0_r) ? (t0_r - t_r) : (t_r - t0_r), 16'd0, 1'b0};
        rem_r <= '0;
        bit_r <= 6'd48;
        ax_r <= '0;
      end
      S_DIV: begin
        if (!rtry[33]) begin
          rem_r <= rtry[32:0];
          quo_r <= {quo_r[47:0], 1'b1};
        end else begin
          rem_r <= rshift[32:0];
          quo_r <= {quo_r[47:0], 1'b0};
        end
        bit_r <= bit_r - 6'd1;
        if (bit_r == 6'd0) begin
          fval_r <= fneg_r ? -$signed({1'b0, quo_r[48:0]}) : $signed({1'b0, quo_r[48:0]});
        end
      end
      S_MUL: prod_r <= 83'(mul_w);
      S_MULH: prod_r <= prod_r + (83'(mul_w) <<< 25);
      S_ADD: begin
        res_r[ax_r] <= sat_w;
        ax_r <= ax_r + 2'd1;
        stat_r <= kps_pkg::StOk;
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/keyframe_position_sampler.sv =====
// ----------------------------------------------------------------------------
// keyframe_position_sampler
// Linear interpolation over a stored track of 3D position keys.
// ----------------------------------------------------------------------------
// Input channel in_*: func 0 writes a key to slot key_index, func 1 samples
// the track at sample_time. Result channel out_*: one item per sample.
// cfg_we/cfg_wdata set key_count; write it only while the block is idle.
// A write item waits until no sample is pending. A sample searches the keys
// (one RAM read per key), fetches the segment, divides serially one quotient
// bit at a time and runs the three multiply-add passes, each a low and a
// high multiply followed by an add.
// Samples queue two deep in front of the back end, so the next sample can be
// taken while a result waits on out_ready. A stalled result holds.
// Reset empties the queue, sets key_count to 1; key storage is undefined.
// ----------------------------------------------------------------------------
`include "keyframe_position_sampler_assert.svh"
module keyframe_position_sampler #(
  parameter int MaxKeys = kps_pkg::MaxKeysDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_time,
  input  logic [31:0] in_key_x,
  input  logic [31:0] in_key_y,
  input  logic [31:0] in_key_z,
  input  logic [31:0] in_sample_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  localparam int AW = $clog2(MaxKeys);
  logic [6:0] count_r;
  logic key_we, cmd_valid, cmd_ready, busy;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] rd_t, rd_x, rd_y, rd_z;
  kps_pkg::kps_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 7'd1;
    else if (cfg_we) count_r <= cfg_wdata;
  end

  kps_front #(.MaxKeys(MaxKeys)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_key_index,
    .count(count_r), .in_sample_time, .back_busy(busy),
    .key_we, .key_waddr(waddr), .cmd_valid, .cmd_ready, .cmd
  );

  kps_ram #(.Width(32), .Depth(MaxKeys)) u_t (.clk, .we(key_we), .waddr,
    .wdata(in_key_time), .raddr, .rdata(rd_t));
  kps_ram #(.Width(32), .Depth(MaxKeys)) u_x (.clk, .we(key_we), .waddr,
    .wdata(in_key_x), .raddr, .rdata(rd_x));
  kps_ram #(.Width(32), .Depth(MaxKeys)) u_y (.clk, .we(key_we), .waddr,
    .wdata(in_key_y), .raddr, .rdata(rd_y));
  kps_ram #(.Width(32), .Depth(MaxKeys)) u_z (.clk, .we(key_we), .waddr,
    .wdata(in_key_z), .raddr, .rdata(rd_z));

  kps_back #(.MaxKeys(MaxKeys)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .busy, .raddr,
    .rd_t, .rd_x, .rd_y, .rd_z, .out_valid, .out_ready,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_status
  );

  `KPS_ASSERT_IMP(a_no_write_busy, key_we, !busy)
  `KPS_ASSERT_IMP(a_status_code, out_valid,
    out_status == kps_pkg::StOk || out_status == kps_pkg::StSingle ||
    out_status == kps_pkg::StZeroSpan)
  `KPS_ASSERT_NXT(a_pop_busy, cmd_valid && cmd_ready, busy)
endmodule
